// File: src/spaq_pkg.sv
// Shared types and constants for the sorted array priority queue.
`timescale 1ns / 1ps
package spaq_pkg;

    localparam int DEPTH  = 8;
    localparam int PRIO_W = 8;
    localparam int TAG_W  = 16;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int EXT_W  = (CNT_W > 4) ? CNT_W : 4;

    localparam logic [CMD_W-1:0] CMD_ENQ  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEQ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_OVER  = 2'd1;
    localparam logic [STAT_W-1:0] ST_UNDER = 2'd2;

    typedef struct packed {
        logic              enq;
        logic              deq;
        logic [PRIO_W-1:0] prio;
        logic [TAG_W-1:0]  tag;
    } t_cell_ctrl;

endpackage

// File: src/spaq_cell.sv
// One storage cell of the sorted chain: holds an entry and shifts it to a neighbor.
`timescale 1ns / 1ps
module spaq_cell (
    input  logic                       i_clk,
    input  spaq_pkg::t_cell_ctrl       i_ctrl,
    input  logic                       i_occupied,
    input  logic                       i_left_after,
    input  logic [spaq_pkg::PRIO_W-1:0] i_left_prio,
    input  logic [spaq_pkg::TAG_W-1:0]  i_left_tag,
    input  logic [spaq_pkg::PRIO_W-1:0] i_right_prio,
    input  logic [spaq_pkg::TAG_W-1:0]  i_right_tag,
    output logic [spaq_pkg::PRIO_W-1:0] o_prio,
    output logic [spaq_pkg::TAG_W-1:0]  o_tag,
    output logic                       o_after
);
    import spaq_pkg::*;

    logic [PRIO_W-1:0] r_prio;
    logic [TAG_W-1:0]  r_tag;
    logic [PRIO_W-1:0] n_prio;
    logic [TAG_W-1:0]  n_tag;

    // The held entry stays ahead of a new one when its priority is not larger.
    assign o_after = i_occupied && (r_prio <= i_ctrl.prio);

    always_comb begin
        n_prio = r_prio;
        n_tag  = r_tag;
        if (i_ctrl.enq && !o_after) begin
            if (i_left_after) begin
                n_prio = i_ctrl.prio;
                n_tag  = i_ctrl.tag;
            end else begin
                n_prio = i_left_prio;
                n_tag  = i_left_tag;
            end
        end else if (i_ctrl.deq) begin
            n_prio = i_right_prio;
            n_tag  = i_right_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prio <= n_prio;
        r_tag  <= n_tag;
    end

    assign o_prio = r_prio;
    assign o_tag  = r_tag;

endmodule

// File: src/sorted_array_priority_queue.sv
// Top level of the sorted array priority queue: cell chain, occupancy and result register.
`timescale 1ns / 1ps
// A bounded priority queue of DEPTH entries kept in a chain of cells sorted by ascending
// priority, with equal priorities kept in arrival order. Each input beat is an enqueue,
// a dequeue or a peek, and produces exactly one result beat that describes the queue
// after the operation. Every cell compares its entry with the incoming priority in the
// same cycle and either keeps its entry, loads the new one or takes its neighbor's. The
// block accepts one beat per cycle while no result waits or the waiting one is taken,
// and the result appears in the output register in the cycle after acceptance. Input
// keeps being accepted while a result waits, if that result is taken in the same cycle.
module sorted_array_priority_queue (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [spaq_pkg::CMD_W-1:0]   i_command,
    input  logic [spaq_pkg::PRIO_W-1:0]  i_in_priority,
    input  logic [spaq_pkg::TAG_W-1:0]   i_in_tag,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [spaq_pkg::STAT_W-1:0]  o_status,
    output logic [spaq_pkg::PRIO_W-1:0]  o_out_priority,
    output logic [spaq_pkg::TAG_W-1:0]   o_out_tag,
    output logic [spaq_pkg::PRIO_W-1:0]  o_head_priority,
    output logic [spaq_pkg::TAG_W-1:0]   o_head_tag,
    output logic [spaq_pkg::PRIO_W-1:0]  o_tail_priority,
    output logic [spaq_pkg::TAG_W-1:0]   o_tail_tag,
    output logic [3:0]                   o_count,
    output logic                         o_empty_res,
    output logic                         o_full_res
);
    import spaq_pkg::*;

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_out_valid;
    logic [STAT_W-1:0] r_status;
    logic [PRIO_W-1:0] r_out_prio;
    logic [TAG_W-1:0]  r_out_tag;
    logic [PRIO_W-1:0] r_head_prio;
    logic [TAG_W-1:0]  r_head_tag;
    logic [PRIO_W-1:0] r_tail_prio;
    logic [TAG_W-1:0]  r_tail_tag;
    logic [CNT_W-1:0]  r_res_count;

    logic              w_accept;
    logic              w_full;
    logic              w_empty;
    logic              w_is_enq;
    logic              w_is_deq;
    logic              w_enq_ok;
    logic              w_deq_ok;
    t_cell_ctrl        w_ctrl;

    logic [PRIO_W-1:0] w_prio [DEPTH];
    logic [TAG_W-1:0]  w_tag  [DEPTH];
    logic              w_after [DEPTH];

    logic [PRIO_W-1:0] w_old_tail_prio;
    logic [TAG_W-1:0]  w_old_tail_tag;
    logic              w_tail_after;

    logic [STAT_W-1:0] w_status;
    logic [PRIO_W-1:0] w_rem_prio;
    logic [TAG_W-1:0]  w_rem_tag;
    logic [PRIO_W-1:0] w_head_prio;
    logic [TAG_W-1:0]  w_head_tag;
    logic [PRIO_W-1:0] w_tail_prio;
    logic [TAG_W-1:0]  w_tail_tag;
    logic [EXT_W-1:0]  w_count_ext;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_full     = (r_count == CNT_W'(DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_is_enq   = (i_command == CMD_ENQ);
    assign w_is_deq   = (i_command == CMD_DEQ);
    assign w_enq_ok   = w_is_enq && !w_full;
    assign w_deq_ok   = w_is_deq && !w_empty;

    assign w_ctrl.enq  = w_accept && w_enq_ok;
    assign w_ctrl.deq  = w_accept && w_deq_ok;
    assign w_ctrl.prio = i_in_priority;
    assign w_ctrl.tag  = i_in_tag;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic              w_occ;
        logic              w_left_after;
        logic [PRIO_W-1:0] w_left_prio;
        logic [TAG_W-1:0]  w_left_tag;
        logic [PRIO_W-1:0] w_right_prio;
        logic [TAG_W-1:0]  w_right_tag;

        assign w_occ = (r_count > CNT_W'(g));

        if (g == 0) begin : g_first
            assign w_left_after = 1'b1;
            assign w_left_prio  = i_in_priority;
            assign w_left_tag   = i_in_tag;
        end else begin : g_rest
            assign w_left_after = w_after[g-1];
            assign w_left_prio  = w_prio[g-1];
            assign w_left_tag   = w_tag[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right_prio = w_prio[g];
            assign w_right_tag  = w_tag[g];
        end else begin : g_inner
            assign w_right_prio = w_prio[g+1];
            assign w_right_tag  = w_tag[g+1];
        end

        spaq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_occupied   (w_occ),
            .i_left_after (w_left_after),
            .i_left_prio  (w_left_prio),
            .i_left_tag   (w_left_tag),
            .i_right_prio (w_right_prio),
            .i_right_tag  (w_right_tag),
            .o_prio       (w_prio[g]),
            .o_tag        (w_tag[g]),
            .o_after      (w_after[g])
        );
    end

    always_comb begin
        w_old_tail_prio = '0;
        w_old_tail_tag  = '0;
        w_tail_after    = 1'b0;
        for (int k = 0; k < DEPTH; k++) begin
            if (r_count == CNT_W'(k + 1)) begin
                w_old_tail_prio = w_prio[k];
                w_old_tail_tag  = w_tag[k];
                w_tail_after    = w_after[k];
            end
        end
    end

    always_comb begin
        n_count    = r_count;
        w_status   = ST_OK;
        w_rem_prio = '0;
        w_rem_tag  = '0;
        if (w_is_enq && w_full) begin
            w_status = ST_OVER;
        end else if (w_is_deq && w_empty) begin
            w_status = ST_UNDER;
        end
        if (w_enq_ok) begin
            n_count = r_count + 1'b1;
        end else if (w_deq_ok) begin
            n_count    = r_count - 1'b1;
            w_rem_prio = w_prio[0];
            w_rem_tag  = w_tag[0];
        end
    end

    always_comb begin
        w_head_prio = w_prio[0];
        w_head_tag  = w_tag[0];
        w_tail_prio = w_old_tail_prio;
        w_tail_tag  = w_old_tail_tag;
        if (w_enq_ok) begin
            if (!w_after[0]) begin
                w_head_prio = i_in_priority;
                w_head_tag  = i_in_tag;
            end
            if (w_empty || w_tail_after) begin
                w_tail_prio = i_in_priority;
                w_tail_tag  = i_in_tag;
            end
        end else if (w_deq_ok) begin
            w_head_prio = w_prio[1];
            w_head_tag  = w_tag[1];
        end
        if (n_count == '0) begin
            w_head_prio = '0;
            w_head_tag  = '0;
            w_tail_prio = '0;
            w_tail_tag  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status    <= w_status;
            r_out_prio  <= w_rem_prio;
            r_out_tag   <= w_rem_tag;
            r_head_prio <= w_head_prio;
            r_head_tag  <= w_head_tag;
            r_tail_prio <= w_tail_prio;
            r_tail_tag  <= w_tail_tag;
            r_res_count <= n_count;
        end
    end

    assign w_count_ext     = EXT_W'(r_res_count);
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_out_priority  = r_out_prio;
    assign o_out_tag       = r_out_tag;
    assign o_head_priority = r_head_prio;
    assign o_head_tag      = r_head_tag;
    assign o_tail_priority = r_tail_prio;
    assign o_tail_tag      = r_tail_tag;
    assign o_count         = w_count_ext[3:0];
    assign o_empty_res     = (r_res_count == '0);
    assign o_full_res      = (r_res_count == CNT_W'(DEPTH));

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("Occupancy exceeds the queue depth.");

    a_over_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_OVER)) |-> o_full_res)
        else $error("Overflow reported while the queue is not full.");

    a_under_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_UNDER)) |-> o_empty_res)
        else $error("Underflow reported while the queue is not empty.");

    a_deq_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_deq_ok) |=> (r_count == CNT_W'($past(r_count) - 1'b1)))
        else $error("Dequeue did not lower the occupancy by one.");

endmodule
